[design/rgb_to_hsv_converter_assert.svh]
// Assertion macros for the RGB to HSV converter.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// cond holds in the same cycle as trig
`define RHC_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("rgb_to_hsv_converter: assertion failed");

// cond holds in the cycle after trig
`define RHC_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("rgb_to_hsv_converter: assertion failed");

`endif

[design/rhc_pkg.sv]
`timescale 1ns / 1ps
package rhc_pkg;

  localparam int CH_W          = 8;
  localparam int HUE_W         = 15;
  localparam int SAT_W         = 16;
  localparam int HUE_FRAC_BITS = 6;
  localparam int HUE_SCALE     = 60 * (1 << HUE_FRAC_BITS);
  localparam int HUE_Q_W       = $clog2(360 * (1 << HUE_FRAC_BITS));
  localparam int STEPS         = (SAT_W > HUE_Q_W) ? SAT_W : HUE_Q_W;
  localparam int DVD_W         = STEPS + CH_W;
  localparam int TERM_W        = $clog2(6 * ((1 << CH_W) - 1) + 1);
  localparam int LATENCY       = STEPS + 3;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  brightness;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic              gray;
    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   delta;
    logic [TERM_W-1:0] term;
  } sector_t;

  typedef struct packed {
    logic             valid;
    logic             gray;
    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  delta;
    logic [CH_W-1:0]  sat_rem;
    logic [STEPS-1:0] sat_lo;
    logic [CH_W-1:0]  hue_rem;
    logic [STEPS-1:0] hue_lo;
  } cell_t;

endpackage

[design/rhc_prep.sv]
`timescale 1ns / 1ps
module rhc_prep import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  pixel_t pixel,
  output cell_t  head
);

  logic [CH_W-1:0]   mx;
  logic [CH_W-1:0]   mn;
  logic [CH_W-1:0]   delta;
  logic [TERM_W-1:0] term;
  sector_t           sector;
  sector_t           sector_next;
  cell_t             head_next;
  logic [DVD_W-1:0]  sat_dvd;
  logic [DVD_W-1:0]  hue_dvd;

  always_comb begin
    mx = (pixel.red > pixel.green) ? pixel.red : pixel.green;
    if (pixel.blue > mx) begin
      mx = pixel.blue;
    end
    mn = (pixel.red < pixel.green) ? pixel.red : pixel.green;
    if (pixel.blue < mn) begin
      mn = pixel.blue;
    end
    delta = mx - mn;
    if (pixel.red == mx) begin
      if (pixel.green >= pixel.blue) begin
        term = TERM_W'(pixel.green - pixel.blue);
      end else begin
        term = TERM_W'(6) * TERM_W'(delta) - TERM_W'(pixel.blue - pixel.green);
      end
    end else if (pixel.green == mx) begin
      term = TERM_W'(2) * TERM_W'(delta) + TERM_W'(pixel.blue) - TERM_W'(pixel.red);
    end else begin
      term = TERM_W'(4) * TERM_W'(delta) + TERM_W'(pixel.red) - TERM_W'(pixel.green);
    end
    sector_next.valid = load;
    sector_next.gray  = (delta == '0);
    sector_next.mx    = mx;
    sector_next.delta = delta;
    sector_next.term  = term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sector <= '0;
    end else begin
      sector <= sector_next;
    end
  end

  always_comb begin
    sat_dvd = (DVD_W'(sector.delta) << SAT_W) - DVD_W'(sector.delta);
    hue_dvd = DVD_W'(sector.term) * DVD_W'(HUE_SCALE);
    head_next.valid   = sector.valid;
    head_next.gray    = sector.gray;
    head_next.mx      = sector.mx;
    head_next.delta   = sector.delta;
    head_next.sat_rem = sat_dvd[DVD_W-1:STEPS];
    head_next.sat_lo  = sat_dvd[STEPS-1:0];
    head_next.hue_rem = hue_dvd[DVD_W-1:STEPS];
    head_next.hue_lo  = hue_dvd[STEPS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= head_next;
    end
  end

endmodule

[design/rhc_cell.sv]
`timescale 1ns / 1ps
module rhc_cell import rhc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cell_t prev,
  output cell_t stage
);

  logic [CH_W:0] sat_t;
  logic [CH_W:0] hue_t;
  logic          sat_ge;
  logic          hue_ge;
  cell_t         stage_next;

  always_comb begin
    sat_t  = {prev.sat_rem, prev.sat_lo[STEPS-1]};
    hue_t  = {prev.hue_rem, prev.hue_lo[STEPS-1]};
    sat_ge = (sat_t >= {1'b0, prev.mx});
    hue_ge = (hue_t >= {1'b0, prev.delta});
    stage_next = prev;
    stage_next.sat_rem = sat_ge ? CH_W'(sat_t - {1'b0, prev.mx}) : CH_W'(sat_t);
    stage_next.hue_rem = hue_ge ? CH_W'(hue_t - {1'b0, prev.delta}) : CH_W'(hue_t);
    stage_next.sat_lo  = {prev.sat_lo[STEPS-2:0], sat_ge};
    stage_next.hue_lo  = {prev.hue_lo[STEPS-2:0], hue_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= stage_next;
    end
  end

endmodule

[design/rgb_to_hsv_converter.sv]
`timescale 1ns / 1ps
// RGB to HSV converter, one 8-bit RGB pixel in, one HSV result out.
// Input: drive pixel and raise start; the transaction is taken at a rising
//   edge where start is high and busy is low. busy is high only during reset,
//   so a new pixel can be taken on every clock.
// Output: done is high for exactly one cycle with result valid in that cycle;
//   the receiver has no way to stall, so it must take every result.
// result.hue is hue in 1/64 degree, result.saturation is 65535*(max-min)/max,
//   result.brightness is the largest channel. Gray pixels give hue and
//   saturation of zero.
// Throughput: one pixel per cycle while busy is low, that is outside reset.
// Two setup stages find max, min and hue sector, then a row of 16 cells each
//   yields one quotient bit of both divisions; an output register follows.
// Results come out in the order the pixels went in.
// Reset clears every valid flag in the pipeline; pixels in flight are dropped
//   and no done pulse follows reset until a new pixel is taken.
module rgb_to_hsv_converter import rhc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  pixel_t  pixel,
  output logic    done,
  output result_t result
);

  cell_t chain [STEPS+1];
  logic  accept;

  assign busy   = rst;
  assign accept = start && !busy;

  rhc_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .pixel (pixel),
    .head  (chain[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    rhc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .prev  (chain[i]),
      .stage (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    result.brightness <= chain[STEPS].mx;
    result.saturation <= chain[STEPS].gray ? '0 : chain[STEPS].sat_lo[SAT_W-1:0];
    result.hue        <= chain[STEPS].gray ? '0 : chain[STEPS].hue_lo[HUE_W-1:0];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[STEPS].valid;
    end
  end

`include "rgb_to_hsv_converter_assert.svh"

  `RHC_ASSERT_NOW(a_latency, 1'b1, done == $past(accept, LATENCY))
  `RHC_ASSERT_NOW(a_gray_hue, done && (result.saturation == '0), result.hue == '0)
  `RHC_ASSERT_NOW(a_black_sat, done && (result.brightness == '0), result.saturation == '0)
  `RHC_ASSERT_NOW(a_head_flow, $past(accept, 2), chain[0].valid)

endmodule

[bench/hsv_result_checker.sv]
`timescale 1ns / 1ps
module hsv_result_checker import rhc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  pixel_t  pixel,
  input  logic    done,
  input  result_t result,
  output int      mismatches,
  output int      outstanding
);

  result_t expected_hsv[$];

  function automatic result_t hsv_of(pixel_t p);
    longint r, g, b, mx, mn, delta, scale, num;
    result_t res;
    r = p.red;
    g = p.green;
    b = p.blue;
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    delta = mx - mn;
    res = '0;
    res.brightness = mx[CH_W-1:0];
    if (delta != 0) begin
      scale = 60 * (longint'(1) << HUE_FRAC_BITS);
      res.saturation = SAT_W'((65535 * delta) / mx);
      if (r == mx) begin
        num = scale * (g - b);
        if (num < 0) num += 6 * scale * delta;
      end else if (g == mx) begin
        num = scale * (2 * delta + b - r);
      end else begin
        num = scale * (4 * delta + r - g);
      end
      res.hue = HUE_W'(num / delta);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (expected_hsv.size() == 0) begin
          $error("result with no transaction pending: hue %0d saturation %0d brightness %0d",
                 result.hue, result.saturation, result.brightness);
          mismatches++;
        end else begin
          want = expected_hsv.pop_front();
          if (result.hue !== want.hue) begin
            $error("hue: expected %0d, actual %0d", want.hue, result.hue);
            mismatches++;
          end
          if (result.saturation !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation, result.saturation);
            mismatches++;
          end
          if (result.brightness !== want.brightness) begin
            $error("brightness: expected %0d, actual %0d", want.brightness, result.brightness);
            mismatches++;
          end
        end
      end
      if (start && !busy) expected_hsv = {expected_hsv, hsv_of(pixel)};
      outstanding = expected_hsv.size();
    end
  end

endmodule

[bench/rgb_to_hsv_converter_tb.sv]
`timescale 1ns / 1ps
module rgb_to_hsv_converter_tb;
  import rhc_pkg::*;

  localparam int RANDOM_PIXELS = 700;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  pixel_t  pixel = '0;
  logic    done;
  result_t result;
  int      mismatches;
  int      outstanding;

  always #5 clk = ~clk;

  rgb_to_hsv_converter u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .pixel  (pixel),
    .done   (done),
    .result (result)
  );

  hsv_result_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .pixel       (pixel),
    .done        (done),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic pixel_t make_pixel(int r, int g, int b);
    pixel_t p;
    p.red = r[CH_W-1:0];
    p.green = g[CH_W-1:0];
    p.blue = b[CH_W-1:0];
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int base;
    p = make_pixel($urandom, $urandom, $urandom);
    case ($urandom_range(0, 9))
      0: begin
        p.green = p.red;
        p.blue = p.red;
      end
      1: begin
        case ($urandom_range(0, 2))
          0: p.green = p.red;
          1: p.blue = p.red;
          default: p.blue = p.green;
        endcase
      end
      2: begin
        base = $urandom_range(0, 250);
        p = make_pixel(base + $urandom_range(0, 5), base + $urandom_range(0, 5),
                       base + $urandom_range(0, 5));
      end
      3: begin
        if ($urandom_range(0, 1)) p.red = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 1)) p.green = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 1)) p.blue = $urandom_range(0, 1) ? '1 : '0;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_pixel(pixel_t p);
    @(negedge clk);
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_idle(int cycles);
    @(negedge clk);
    start <= 1'b0;
    pixel <= make_pixel($urandom, $urandom, $urandom);
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    pixel_t directed[$];
    directed = '{
      make_pixel(0, 0, 0),       make_pixel(255, 255, 255), make_pixel(128, 128, 128),
      make_pixel(255, 0, 0),     make_pixel(0, 255, 0),     make_pixel(0, 0, 255),
      make_pixel(255, 0, 1),     make_pixel(200, 10, 90),   make_pixel(255, 255, 0),
      make_pixel(255, 0, 255),   make_pixel(0, 255, 255),   make_pixel(1, 0, 0),
      make_pixel(0, 1, 0),       make_pixel(0, 0, 1),       make_pixel(255, 254, 254),
      make_pixel(254, 255, 254), make_pixel(254, 254, 255), make_pixel(100, 50, 100),
      make_pixel(30, 200, 200),  make_pixel(1, 255, 0),     make_pixel(0, 1, 255),
      make_pixel(170, 85, 0)
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_pixel(directed[i]);
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if ((i < 300 || i >= 450) && $urandom_range(0, 99) < 9)
        hold_idle($urandom_range(1, 4));
      send_pixel(random_pixel());
    end
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
